// ===== rtl/core/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, field widths and defaults for the multichannel moving-average
// filter.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int CHANNELS_DEF   = 8;
  localparam int WINDOW_MAX_DEF = 32;

  localparam int SAMPLE_W    = 24;
  localparam int CHAN_W      = 3;
  localparam int LEN_FIELD_W = 6;

  localparam logic [LEN_FIELD_W-1:0] LEN_RESET = LEN_FIELD_W'(4);

  typedef struct packed {
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [CHAN_W-1:0]          out_channel;
    logic                       out_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving average over several channels with per-channel running sums.
// ----------------------------------------------------------------------------
// One item at a time. A sample of an already primed channel goes from its
// input transfer through ST_UPDATE and the serial divider (ST_DIV) to the
// output register, and the next item is taken only after that result is
// loaded. The divider takes the SUM_W = 24 + log2(WINDOW_MAX) bit sum and
// yields one quotient bit per cycle. A channel's first sample after reset or
// after a length write passes through ST_FILL first, since the window memory's
// single write port fills the channel's len slots one per cycle. A channel
// number at or above CHANNELS yields a zero average, through ST_DONE.
// The window samples and running sums live in two synchronous memories; the
// result sits in an output register, so a new item may transfer while the
// previous result still waits.
module multichannel_moving_average #(
  parameter int CHANNELS   = mma_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX = mma_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mma_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mma_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mma_pkg::LEN_FIELD_W-1:0]     cfg_wdata
);
  import mma_pkg::*;

  localparam int POS_W  = $clog2(WINDOW_MAX);
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  state_t state;
  state_t state_next;

  logic [LEN_FIELD_W-1:0]     window_len;
  logic [POS_W-1:0]           window_pos;
  logic [CHANNELS-1:0]        primed;

  logic [CHAN_W-1:0]          ch_item;
  logic signed [SAMPLE_W-1:0] sample_item;
  logic                       last_item;
  logic                       hit_item;
  logic [LEN_W-1:0]           len_item;
  logic [ADDR_W-1:0]          addr_item;
  logic [LEN_W-1:0]           fill_cnt;

  // window and sum memories
  logic signed [SAMPLE_W-1:0] win_mem [DEPTH];
  logic signed [SAMPLE_W-1:0] win_rd;
  logic signed [SUM_W-1:0]    sum_mem [CHANNELS];
  logic signed [SUM_W-1:0]    sum_rd;

  logic                       accept;
  logic [LEN_W-1:0]           len_eff;
  logic [POS_W-1:0]           pos_cur;
  logic [POS_W-1:0]           pos_adv;
  logic                       in_hit;
  logic [CH_W-1:0]            in_idx;
  logic [CH_W-1:0]            item_idx;
  logic [ADDR_W-1:0]          in_addr;
  logic [ADDR_W-1:0]          fill_addr;
  logic                       fill_last;
  logic                       out_free;

  logic signed [SUM_W-1:0]    sum_prime;
  logic signed [SUM_W-1:0]    sum_upd;

  logic                       win_we;
  logic [ADDR_W-1:0]          win_wr_addr;
  logic                       sum_we;
  logic signed [SUM_W-1:0]    sum_wr_data;
  logic                       div_start;
  logic signed [SUM_W-1:0]    div_dividend;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quot;
  logic                       out_load;

  always_comb begin
    if (window_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(window_len) > WINDOW_MAX) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(window_len);
    end
    pos_cur = (32'(window_pos) >= 32'(len_eff)) ? '0 : window_pos;
    pos_adv = (32'(pos_cur) + 1 == 32'(len_eff)) ? '0 : POS_W'(32'(pos_cur) + 1);
    in_hit    = 32'(in_data.channel) < CHANNELS;
    in_idx    = CH_W'(in_data.channel);
    item_idx  = CH_W'(ch_item);
    in_addr   = ADDR_W'(32'(pos_cur) * CHANNELS + 32'(in_data.channel));
    fill_addr = ADDR_W'(32'(fill_cnt) * CHANNELS + 32'(ch_item));
    fill_last = fill_cnt == LEN_W'(len_item - 1'b1);
    sum_prime = SUM_W'(sample_item) * $signed(SUM_W'(len_item));
    sum_upd   = sum_rd - SUM_W'(win_rd) + SUM_W'(sample_item);
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_hit) begin
            state_next = ST_DONE;
          end else if (!primed[in_idx]) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_DIV;
        end
      end
      ST_UPDATE: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = out_free ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall     = state != ST_IDLE;
    win_we       = 1'b0;
    win_wr_addr  = addr_item;
    sum_we       = 1'b0;
    sum_wr_data  = sum_upd;
    div_start    = 1'b0;
    div_dividend = sum_upd;
    out_load     = 1'b0;
    case (state)
      ST_FILL: begin
        win_we      = 1'b1;
        win_wr_addr = fill_addr;
        if (fill_last) begin
          sum_we       = 1'b1;
          sum_wr_data  = sum_prime;
          div_start    = 1'b1;
          div_dividend = sum_prime;
        end
      end
      ST_UPDATE: begin
        win_we    = 1'b1;
        sum_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:  out_load = div_done && out_free;
      ST_DONE: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_wr_addr] <= sample_item;
    end
    if (accept && in_hit) begin
      win_rd <= win_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[item_idx] <= sum_wr_data;
    end
    if (accept && in_hit) begin
      sum_rd <= sum_mem[in_idx];
    end
  end

  mma_div #(
    .SUM_W(SUM_W),
    .LEN_W(LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (len_item),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window_len <= LEN_RESET;
      window_pos <= '0;
      primed     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window_len <= cfg_wdata;
        window_pos <= '0;
        primed     <= '0;
      end else if (accept) begin
        window_pos <= in_data.frame_end ? pos_adv : pos_cur;
        if (in_hit) begin
          primed[in_idx] <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      ch_item     <= in_data.channel;
      sample_item <= in_data.sample;
      last_item   <= in_data.frame_end;
      hit_item    <= in_hit;
      len_item    <= len_eff;
      addr_item   <= in_addr;
      fill_cnt    <= '0;
    end else if (state == ST_FILL) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
    if (out_load) begin
      out_data.average     <= hit_item ? div_quot : '0;
      out_data.out_channel <= ch_item;
      out_data.out_last    <= last_item;
    end
  end

endmodule

// ===== rtl/core/mma_div.sv =====
// ----------------------------------------------------------------------------
// mma_div
// Serial signed divider: window sum by window length, one quotient bit per
// cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module mma_div #(
  parameter int SUM_W = 29,
  parameter int LEN_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [SUM_W-1:0]              dividend,
  input  logic [LEN_W-1:0]                     divisor,
  output logic                                 done,
  output logic signed [mma_pkg::SAMPLE_W-1:0]  quotient
);
  import mma_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] quo;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic             neg;

  logic [SUM_W-1:0] mag;
  logic [LEN_W:0]   rem_sh;
  logic             fits;
  logic [LEN_W-1:0] rem_next;
  logic [SUM_W-1:0] quo_signed;

  always_comb begin
    mag      = dividend[SUM_W-1] ? SUM_W'(~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
    rem_sh   = {rem, quo[SUM_W-1]};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? LEN_W'(rem_sh - {1'b0, dvs}) : LEN_W'(rem_sh);
    quo_signed = neg ? SUM_W'(~quo + 1'b1) : quo;
    quotient = $signed(SAMPLE_W'(quo_signed));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/mma_checker.sv =====
// ----------------------------------------------------------------------------
// mma_checker
// Port-level checks for the multichannel moving-average filter.
// ----------------------------------------------------------------------------
module mma_checker #(
  parameter int CHANNELS = mma_pkg::CHANNELS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input mma_pkg::in_item_t                in_data,
  input logic                             out_valid,
  input logic                             out_stall,
  input mma_pkg::out_item_t               out_data
);
  import mma_pkg::*;

  logic [CHAN_W-1:0] last_ch;
  logic              last_fe;

  // remember the most recent input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      last_ch <= in_data.channel;
      last_fe <= in_data.frame_end;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in progress");

  a_tag_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> out_data.out_channel == last_ch && out_data.out_last == last_fe)
    else $error("result tag does not match the transferred item");

  a_unknown_channel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && 32'(out_data.out_channel) >= CHANNELS |-> out_data.average == '0)
    else $error("nonzero average for a channel out of range");

endmodule

bind multichannel_moving_average mma_checker #(.CHANNELS(CHANNELS)) u_mma_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives channel samples through the moving-average filter under random idle
// and stall, predicts each window average from its own copy of the sums and
// window, and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mma_pkg::*;

  localparam int CHANNELS    = CHANNELS_DEF;
  localparam int WINDOW_MAX  = WINDOW_MAX_DEF;
  localparam int SUM_W       = SAMPLE_W + 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_ITEMS = 120;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [LEN_FIELD_W-1:0] cfg_wdata = '0;

  // predictor state
  logic signed [SAMPLE_W-1:0] hist_mem [CHANNELS*WINDOW_MAX];
  logic signed [SUM_W-1:0]    chan_sum [CHANNELS];
  logic [CHANNELS-1:0]        chan_primed;
  logic [4:0]                 frame_pos;
  logic [LEN_FIELD_W-1:0]     len_reg;

  in_item_t  sample_q [$];
  out_item_t avg_expect_q [$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  gap_on = 1'b1;
  bit  stall_on = 1'b1;

  multichannel_moving_average u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t predict_average(in_item_t it);
    out_item_t               r;
    int                      n;
    int                      slot;
    logic signed [SUM_W-1:0] q;
    n = (len_reg == 0) ? 1 : ((len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(len_reg));
    if (frame_pos >= n) frame_pos = '0;
    q = '0;
    if (it.channel < CHANNELS) begin
      if (!chan_primed[it.channel]) begin
        // first sample of the channel fills its whole window
        for (int j = 0; j < n; j++) hist_mem[j*CHANNELS + it.channel] = it.sample;
        chan_sum[it.channel] = SUM_W'(it.sample) * SUM_W'(n);
        chan_primed[it.channel] = 1'b1;
      end else begin
        slot = int'(frame_pos) * CHANNELS + it.channel;
        chan_sum[it.channel] = chan_sum[it.channel] - SUM_W'(hist_mem[slot])
                               + SUM_W'(it.sample);
        hist_mem[slot] = it.sample;
      end
      q = chan_sum[it.channel] / SUM_W'(n);
    end
    if (it.frame_end) frame_pos = 5'((int'(frame_pos) + 1) % n);
    r.average     = q[SAMPLE_W-1:0];
    r.out_channel = it.channel;
    r.out_last    = it.frame_end;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return '1;
      4, 5: return 24'($urandom_range(0, 2047)) - 24'd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_item(input int ch, input logic [SAMPLE_W-1:0] s, input bit last);
    in_item_t it;
    it.channel   = CHAN_W'(ch);
    it.sample    = s;
    it.frame_end = last;
    sample_q.push_back(it);
  endtask

  // Hold until the sender is empty and every expected result has transferred.
  task automatic wait_drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || avg_expect_q.size() != 0);
  endtask

  task automatic write_length(input logic [LEN_FIELD_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_reg     = v;
    chan_primed = '0;
    frame_pos   = '0;
    @(negedge clk);
  endtask

  // input driver
  always @(posedge clk) begin : drive_proc
    logic hold;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      hold = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        avg_expect_q.push_back(predict_average(in_data));
        gap_left = gap_on ? $urandom_range(0, 5) : 0;
      end else if (!in_valid && gap_left > 0) begin
        gap_left--;
      end
      if (!hold) begin
        if (gap_left == 0 && sample_q.size() > 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_proc
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (avg_expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: ch %0d avg %0d last %0b",
                     out_data.out_channel, $signed(out_data.average), out_data.out_last);
        end else begin
          want = avg_expect_q.pop_front();
          if (want.average !== out_data.average ||
              want.out_channel !== out_data.out_channel ||
              want.out_last !== out_data.out_last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: ch exp %0d got %0d, avg exp %0d got %0d, last exp %0b got %0b",
                       want.out_channel, out_data.out_channel,
                       $signed(want.average), $signed(out_data.average),
                       want.out_last, out_data.out_last);
          end
        end
        stall_left = stall_on ? $urandom_range(0, 5) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int plan [7];
    int added;
    int chunk;
    int frame_w;
    int mode;
    logic [LEN_FIELD_W-1:0] new_len;

    plan        = '{0, 1, 2, 32, 33, 63, 4};
    len_reg     = LEN_RESET;
    chan_primed = '0;
    frame_pos   = '0;
    for (int c = 0; c < CHANNELS; c++) chan_sum[c] = '0;

    // directed: extremes, every channel, repeated channel, open frame
    add_item(0, 24'h7FFFFF, 0);
    add_item(1, 24'h800000, 0);
    add_item(2, 24'h000000, 0);
    add_item(3, 24'hFFFFFF, 0);
    add_item(4, 24'h000001, 0);
    add_item(5, 24'h555555, 0);
    add_item(6, 24'hAAAAAA, 0);
    add_item(7, 24'h7FFF00, 1);
    add_item(0, 24'h800000, 0);
    add_item(1, 24'h7FFFFF, 0);
    add_item(2, 24'hFFFFFF, 0);
    add_item(7, 24'h000100, 1);
    add_item(0, 24'h7FFFFF, 0);
    add_item(0, 24'h000000, 0);
    add_item(3, 24'h123456, 1);
    add_item(7, 24'h800000, 1);
    add_item(5, 24'hFFFF00, 0);
    add_item(1, 24'h800000, 1);
    add_item(0, 24'h7FFFFF, 1);
    add_item(6, 24'h000080, 1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait_drain();

    for (int ph = 0; ph < 12; ph++) begin
      new_len = (ph < 7) ? LEN_FIELD_W'(plan[ph]) : LEN_FIELD_W'($urandom_range(0, 63));
      write_length(new_len);
      // short frames on long windows so the window wraps within the phase
      frame_w = (new_len >= 16 || new_len == 0) ? $urandom_range(1, 4) : $urandom_range(1, 8);
      added = 0;
      while (added < PHASE_ITEMS) begin
        mode     = $urandom_range(0, 3);
        gap_on   = mode[0];
        stall_on = mode[1];
        chunk    = $urandom_range(10, 60);
        for (int k = 0; k < chunk; ) begin
          if ($urandom_range(0, 99) < 85) begin
            for (int c = 0; c < frame_w; c++)
              add_item(c, pick_sample(), c == frame_w - 1);
            k += frame_w;
          end else begin
            add_item($urandom_range(0, CHANNELS - 1), pick_sample(), $urandom_range(0, 1));
            k++;
          end
        end
        added += chunk;
        // pause the sender until everything in flight has come back
        wait_drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && avg_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mma_pkg.sv
rtl/core/mma_div.sv
rtl/core/multichannel_moving_average.sv
rtl/core/mma_checker.sv
verif/testbench.sv
